// ----- hw/rtl/mwg_pkg.sv -----
// shared types, constants and the quarter-wave table function for the waveform generator
// no dependencies; used by the interfaces, the table rom, the top level and the checker
package mwg_pkg;

    // default sizes handed to the top level
    localparam int DEF_PHASE_BITS      = 32;
    localparam int DEF_TABLE_ADDR_BITS = 10;
    localparam int DEF_SAMPLE_BITS     = 16;

    // configuration port
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 32;

    // register widths
    localparam int WAVE_BITS = 2;
    localparam int AMP_BITS  = 15;
    localparam int STEP_BITS = 32;
    localparam int RUN_BITS  = 21;
    localparam int IDX_BITS  = 20;

    // register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_WAVEFORM        = 2'd0,
        CFG_AMPLITUDE       = 2'd1,
        CFG_PHASE_STEP      = 2'd2,
        CFG_SAMPLES_PER_RUN = 2'd3
    } cfg_index_t;

    // waveform selection codes
    typedef enum logic [WAVE_BITS-1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_COSINE   = 2'd1,
        WAVE_SQUARE   = 2'd2,
        WAVE_SAWTOOTH = 2'd3
    } wave_t;

    // reset values of the registers
    localparam logic [AMP_BITS-1:0]  AMP_RESET  = 15'd32767;
    localparam logic [STEP_BITS-1:0] STEP_RESET = 32'd8589935;
    localparam logic [RUN_BITS-1:0]  RUN_RESET  = 21'd1000;
    localparam logic [RUN_BITS-1:0]  RUN_MAX    = 21'd1048576;

    // waveform value is signed q1.15 with plus and minus one representable
    localparam int WAVE_VAL_BITS = 17;
    localparam int TBL_DATA_BITS = 17;
    localparam logic signed [WAVE_VAL_BITS-1:0] WAVE_POS_ONE = 17'sh08000;
    localparam logic signed [WAVE_VAL_BITS-1:0] WAVE_NEG_ONE = 17'sh18000;

    // pi/2 in q30
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // shift-and-subtract unsigned quotient, only evaluated while the table is built
    function automatic longint unsigned div_u64(input longint unsigned num,
                                                input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            if (rem >= den)
            begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // one quarter-wave entry: taylor series of sin(pi/2 * i/n) in q30, rounded to q1.15
    function automatic logic [TBL_DATA_BITS-1:0] quarter_sine(input longint unsigned i,
                                                               input int unsigned addr_bits);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned divisor;
        longint          sum;
        x    = (HALF_PI_Q30 * i + ((64'd1 << addr_bits) >> 1)) >> addr_bits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int k = 1; k <= 10; k++)
        begin
            divisor = longint'(unsigned'((2 * k) * (2 * k + 1)));
            term    = div_u64((term * x2) >> 30, divisor);
            if (k[0] == 1'b1)
            begin
                sum = sum - longint'(term);
            end
            else
            begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0)
        begin
            sum = 0;
        end
        if (sum > (longint'(1) << 30))
        begin
            sum = longint'(1) << 30;
        end
        return TBL_DATA_BITS'((longint'(unsigned'(sum)) + 64'd16384) >> 15);
    endfunction

endpackage

// ----- hw/rtl/mwg_ifs.sv -----
// valid/ready channel interfaces: tick input, sample output and configuration writes
// depends on mwg_pkg for the configuration port widths and the default sample width
interface mwg_tick_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface mwg_sample_if #(
    parameter int SAMPLE_BITS = mwg_pkg::DEF_SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface mwg_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [mwg_pkg::CFG_INDEX_BITS-1:0]  index;
    logic [mwg_pkg::CFG_DATA_BITS-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/mwg_quarter_rom.sv -----
// quarter-wave sine rom with a registered read port
// depends on mwg_pkg for the entry function and data width
module mwg_quarter_rom #(
    parameter int TABLE_ADDR_BITS = mwg_pkg::DEF_TABLE_ADDR_BITS
) (
    input  logic                                clk,
    input  logic                                en,
    input  logic [TABLE_ADDR_BITS:0]            addr,
    output logic [mwg_pkg::TBL_DATA_BITS-1:0]   data
);

    localparam int TBL_N = 1 << TABLE_ADDR_BITS;

    typedef logic [mwg_pkg::TBL_DATA_BITS-1:0] rom_t [0:TBL_N];

    function automatic rom_t build_rom();
        rom_t tbl;
        for (int i = 0; i <= TBL_N; i++)
        begin
            tbl[i] = mwg_pkg::quarter_sine(longint'(unsigned'(i)), TABLE_ADDR_BITS);
        end
        return tbl;
    endfunction

    localparam rom_t ROM = build_rom();

    logic [mwg_pkg::TBL_DATA_BITS-1:0] data_reg;

    // synchronous read, held while the stage is stalled
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= ROM[addr];
        end
    end

    assign data = data_reg;

endmodule

// ----- hw/rtl/multi_waveform_generator.sv -----
// top level of the direct digital synthesis waveform generator
// depends on mwg_pkg, the channel interfaces and mwg_quarter_rom
//
// One sample per tick beat, and one tick beat can be taken every clock while the first
// stage is empty or moving: the phase accumulator and run counter update in the cycle the
// tick is accepted, so the loops are the PHASE_BITS add and the run counter step. A sample
// then passes the synchronous quarter-wave rom read (2^TABLE_ADDR_BITS+1 entries, built
// at elaboration), the amplitude multiply, and rounding and saturation into the output
// register. Each stage has its own valid bit and moves up into an empty slot, so a stalled
// output holds back only the full stages behind it; up to 3 samples can be in flight.
// Configuration writes are always taken and must arrive while no sample is in flight.
module multi_waveform_generator #(
    parameter int PHASE_BITS      = mwg_pkg::DEF_PHASE_BITS,
    parameter int TABLE_ADDR_BITS = mwg_pkg::DEF_TABLE_ADDR_BITS,
    parameter int SAMPLE_BITS     = mwg_pkg::DEF_SAMPLE_BITS
) (
    input  logic           clk,
    input  logic           rst_n,
    mwg_tick_if.sink       tick,
    mwg_sample_if.source   samples,
    mwg_cfg_if.sink        cfg
);

    localparam int ADDR_W    = TABLE_ADDR_BITS + 1;
    localparam int WV        = mwg_pkg::WAVE_VAL_BITS;
    localparam int PROD_BITS = mwg_pkg::AMP_BITS + 1 + WV;
    localparam int RND_SHIFT = 31 - SAMPLE_BITS;
    localparam logic signed [PROD_BITS-1:0] RND_HALF = PROD_BITS'(1) <<< (RND_SHIFT - 1);
    localparam logic signed [PROD_BITS-1:0] SMAX =
        PROD_BITS'((longint'(1) << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [PROD_BITS-1:0] SMIN = -SMAX;

    // configuration registers
    mwg_pkg::wave_t                    waveform_reg;
    logic [mwg_pkg::AMP_BITS-1:0]      amplitude_reg;
    logic [mwg_pkg::STEP_BITS-1:0]     phase_step_reg;
    logic [mwg_pkg::RUN_BITS-1:0]      samples_per_run_reg;

    // accumulator state
    logic [PHASE_BITS-1:0]             phase_reg;
    logic [PHASE_BITS-1:0]             phase_next;
    logic [mwg_pkg::IDX_BITS-1:0]      index_reg;
    logic [mwg_pkg::IDX_BITS-1:0]      index_next;

    // stage valid bits and enables
    logic v1_reg, v2_reg, v3_reg;
    logic en1, en2, en3;
    logic tick_acc;

    // stage 0 combinational
    logic [PHASE_BITS-1:0]             ph_cur;
    logic [mwg_pkg::IDX_BITS-1:0]      idx_cur;
    logic [mwg_pkg::RUN_BITS-1:0]      run_len;
    logic                              last0;
    logic [1:0]                        quad0;
    logic [TABLE_ADDR_BITS-1:0]        a0;
    logic [ADDR_W-1:0]                 rom_addr;
    logic                              is_table0;
    logic signed [WV-1:0]              alt0;
    logic [15:0]                       saw0;

    // stage 1 payload
    logic                              is_table1_reg;
    logic                              neg1_reg;
    logic signed [WV-1:0]              alt1_reg;
    logic                              last1_reg;
    logic [mwg_pkg::TBL_DATA_BITS-1:0] rom_data;

    // stage 2 payload
    logic signed [WV-1:0]              wave1;
    logic signed [PROD_BITS-1:0]       prod2_reg;
    logic                              last2_reg;

    // stage 3 output
    logic signed [PROD_BITS-1:0]       rounded;
    logic signed [PROD_BITS-1:0]       scaled;
    logic signed [SAMPLE_BITS-1:0]     sample3_reg;
    logic                              last3_reg;

    // configuration writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waveform_reg        <= mwg_pkg::WAVE_SINE;
            amplitude_reg       <= mwg_pkg::AMP_RESET;
            phase_step_reg      <= mwg_pkg::STEP_RESET;
            samples_per_run_reg <= mwg_pkg::RUN_RESET;
        end
        else if (cfg.valid)
        begin
            case (mwg_pkg::cfg_index_t'(cfg.index))
                mwg_pkg::CFG_WAVEFORM:
                    waveform_reg <= mwg_pkg::wave_t'(cfg.data[mwg_pkg::WAVE_BITS-1:0]);
                mwg_pkg::CFG_AMPLITUDE:
                    amplitude_reg <= cfg.data[mwg_pkg::AMP_BITS-1:0];
                mwg_pkg::CFG_PHASE_STEP:
                    phase_step_reg <= cfg.data[mwg_pkg::STEP_BITS-1:0];
                mwg_pkg::CFG_SAMPLES_PER_RUN:
                    samples_per_run_reg <= cfg.data[mwg_pkg::RUN_BITS-1:0];
                default:
                    ;
            endcase
        end
    end

    // stall chain: a stage moves when the one ahead is empty or moving
    assign en3      = !v3_reg || samples.ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign tick.ready = en1;
    assign tick_acc = tick.valid && en1;

    // run end and next accumulator value
    always_comb
    begin
        ph_cur  = tick.restart ? '0 : phase_reg;
        idx_cur = tick.restart ? '0 : index_reg;
        run_len = (samples_per_run_reg > mwg_pkg::RUN_MAX) ? mwg_pkg::RUN_MAX
                                                           : samples_per_run_reg;
        last0   = ({1'b0, idx_cur} + mwg_pkg::RUN_BITS'(1)) >= run_len;
        if (last0)
        begin
            phase_next = '0;
            index_next = '0;
        end
        else
        begin
            phase_next = ph_cur + PHASE_BITS'(phase_step_reg);
            index_next = idx_cur + mwg_pkg::IDX_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            index_reg <= '0;
        end
        else if (tick_acc)
        begin
            phase_reg <= phase_next;
            index_reg <= index_next;
        end
    end

    // table address and the non-table waveforms
    always_comb
    begin
        quad0 = ph_cur[PHASE_BITS-1 -: 2];
        if (waveform_reg == mwg_pkg::WAVE_COSINE)
        begin
            quad0 = quad0 + 2'd1;
        end
        a0 = ph_cur[PHASE_BITS-3 -: TABLE_ADDR_BITS];
        if (quad0[0])
        begin
            rom_addr = (ADDR_W'(1) << TABLE_ADDR_BITS) - {1'b0, a0};
        end
        else
        begin
            rom_addr = {1'b0, a0};
        end
        is_table0 = (waveform_reg == mwg_pkg::WAVE_SINE) ||
                    (waveform_reg == mwg_pkg::WAVE_COSINE);
        saw0 = ph_cur[PHASE_BITS-1 -: 16];
        if (waveform_reg == mwg_pkg::WAVE_SQUARE)
        begin
            alt0 = ((ph_cur != '0) && !ph_cur[PHASE_BITS-1]) ? mwg_pkg::WAVE_POS_ONE
                                                             : mwg_pkg::WAVE_NEG_ONE;
        end
        else
        begin
            alt0 = {saw0[15], saw0};
        end
    end

    mwg_quarter_rom #(
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
    ) u_rom (
        .clk  (clk),
        .en   (en1),
        .addr (rom_addr),
        .data (rom_data)
    );

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= tick.valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // stage 1 payload alongside the rom read
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            is_table1_reg <= is_table0;
            neg1_reg      <= quad0[1];
            alt1_reg      <= alt0;
            last1_reg     <= last0;
        end
    end

    // stage 2: signed waveform value times amplitude
    always_comb
    begin
        if (is_table1_reg)
        begin
            wave1 = neg1_reg ? -$signed({1'b0, rom_data[WV-2:0]})
                             : $signed({1'b0, rom_data[WV-2:0]});
        end
        else
        begin
            wave1 = alt1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            prod2_reg <= PROD_BITS'($signed({1'b0, amplitude_reg})) * PROD_BITS'(wave1);
            last2_reg <= last1_reg;
        end
    end

    // stage 3: round half up, then saturate
    always_comb
    begin
        rounded = prod2_reg + RND_HALF;
        scaled  = rounded >>> RND_SHIFT;
        if (scaled > SMAX)
        begin
            scaled = SMAX;
        end
        else if (scaled < SMIN)
        begin
            scaled = SMIN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            sample3_reg <= scaled[SAMPLE_BITS-1:0];
            last3_reg   <= last2_reg;
        end
    end

    assign samples.valid       = v3_reg;
    assign samples.sample      = sample3_reg;
    assign samples.last_sample = last3_reg;

endmodule

// ----- hw/rtl/mwg_checker.sv -----
// port-level checks for the waveform generator, bound to the top level
// depends on multi_waveform_generator and its channel interfaces
module mwg_checker #(
    parameter int SAMPLE_BITS = mwg_pkg::DEF_SAMPLE_BITS
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          tick_valid,
    input logic                          tick_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic signed [SAMPLE_BITS-1:0] sample,
    input logic                          last_sample
);

    localparam logic [2:0] PIPE_DEPTH = 3'd3;
    localparam logic signed [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic       in_acc;
    logic       out_acc;
    logic [2:0] inflight_reg;
    logic [2:0] inflight_next;

    assign in_acc  = tick_valid && tick_ready;
    assign out_acc = out_valid && out_ready;

    // beats taken in but not yet delivered
    always_comb
    begin
        inflight_next = inflight_reg + {2'b00, in_acc} - {2'b00, out_acc};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // no sample without a tick behind it
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> (inflight_reg != 3'd0))
        else $error("sample delivered with no tick in flight");

    // never more ticks in flight than pipeline slots
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= PIPE_DEPTH)
        else $error("more ticks in flight than pipeline slots");

    // saturation keeps the output symmetric
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (sample != MOST_NEG))
        else $error("sample at most negative code");

    // stalled output beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(sample) && $stable(last_sample)))
        else $error("stalled sample beat changed");

endmodule

bind multi_waveform_generator mwg_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_mwg_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick_valid  (tick.valid),
    .tick_ready  (tick.ready),
    .out_valid   (samples.valid),
    .out_ready   (samples.ready),
    .sample      (samples.sample),
    .last_sample (samples.last_sample)
);
